FILE: hdl/assert_macros.svh
// Concurrent check helpers, sampled on clk_i and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge out of reset.
`define RTCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expr must never be true out of reset.
`define RTCH_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: hdl/rtch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtch_pkg;

  localparam int CoordW       = 16;
  localparam int MeshW        = 8;
  localparam int TW           = 32;
  localparam int FracW        = 16;
  localparam int MeshCountDef = 256;
  localparam int CfgIdxW      = 3;

  localparam int EdgeW  = CoordW + 1;
  localparam int NormW  = 2 * EdgeW + 1;
  localparam int DenW   = NormW + CoordW + 2;
  localparam int NumW   = NormW + EdgeW + 2;
  localparam int HitW   = 34;
  localparam int WW     = HitW + 1;
  localparam int CrossW = EdgeW + WW + 1;

  localparam int MulAW   = 36;
  localparam int MulBW   = 28;
  localparam int ProdW   = MulAW + MulBW;
  localparam int AccW    = 92;
  localparam int SplitSh = 26;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORG_X = 3'd0,
    CFG_ORG_Y = 3'd1,
    CFG_ORG_Z = 3'd2,
    CFG_DIR_X = 3'd3,
    CFG_DIR_Y = 3'd4,
    CFG_DIR_Z = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
    logic [MeshW-1:0]         mesh_id;
    logic                     last_triangle;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [TW-1:0]    distance_t;
    logic [MeshW-1:0] hit_mesh;
  } out_item_t;

  typedef struct packed {
    logic                    en;
    logic                    clr;
    logic                    neg;
    logic                    hi;
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
  } mac_op_t;

endpackage

`default_nettype wire

FILE: hdl/rtch_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module rtch_mac import rtch_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mac_op_t                op_i,
  output logic signed [AccW-1:0]      acc_o
);

  logic signed [ProdW-1:0] prod_d, prod_q;
  logic                    en_q, clr_q, neg_q, hi_q;
  logic signed [AccW-1:0]  term, addend, acc_d, acc_q;

  assign prod_d = op_i.a * op_i.b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else begin
      en_q <= op_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    clr_q  <= op_i.clr;
    neg_q  <= op_i.neg;
    hi_q   <= op_i.hi;
    acc_q  <= acc_d;
  end

  always_comb begin
    term   = hi_q ? (AccW'(prod_q) <<< SplitSh) : AccW'(prod_q);
    addend = neg_q ? -term : term;
    acc_d  = acc_q;
    if (en_q) begin
      acc_d = (clr_q ? AccW'(0) : acc_q) + addend;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

FILE: hdl/rtch_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rtch_div import rtch_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [TW-1:0]        quo_o
);

  localparam int CntW = $clog2(TW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [TW-1:0]   sh_q, quo_q;
  logic [DenW:0]   rem2;
  logic            ge, ovf;

  assign rem2 = {rem_q, sh_q[TW-1]};
  assign ge   = rem2 >= {1'b0, den_q};
  assign ovf  = (NumW + FracW)'(num_i) >= {den_i, FracW'(0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= !ovf;
        done_q <= ovf;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q  <= cnt_q + 1'b1;
        done_q <= cnt_q == CntW'(TW - 1);
        if (cnt_q == CntW'(TW - 1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= DenW'(num_i[NumW-1:FracW]);
      sh_q  <= {num_i[FracW-1:0], FracW'(0)};
      quo_q <= ovf ? '1 : '0;
    end else if (busy_q) begin
      rem_q <= ge ? DenW'(rem2 - {1'b0, den_q}) : rem2[DenW-1:0];
      sh_q  <= sh_q << 1;
      quo_q <= {quo_q[TW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

FILE: hdl/ray_triangle_closest_hit.sv
// channel | dir | handshake                  | payload
// in      | in  | in_valid_i / in_stall_o    | in_i (in_item_t)
// out     | out | out_valid_o / out_stall_i  | out_o (out_item_t)
// cfg     | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Each triangle runs from accept through the sequencer steps on the single shared
// multiply-accumulate unit (normal, dot products, hit point, edge tests) and the
// 32-step restoring divider, which does no steps when t saturates.
// Reset clears the sequencer, the best hit and the output valid flag; ray registers
// return to origin 0 and direction +z.
// in_stall_o is high while a triangle is in work; a final triangle waits in its last
// step only while the output register is still full and stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ray_triangle_closest_hit import rtch_pkg::*; #(
  parameter int MeshCount = MeshCountDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CoordW-1:0]  cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_NORM = 6'b000010,
    S_DIV  = 6'b000100,
    S_HPT  = 6'b001000,
    S_EDGE = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_d, state_q;
  logic [3:0] step_d, step_q;
  logic [1:0] edge_d, edge_q;

  logic signed [CoordW-1:0] org_q [3];
  logic signed [CoordW-1:0] dir_q [3];
  in_item_t                 item_q;

  logic signed [NormW-1:0]  n_q [3];
  logic signed [DenW-1:0]   q_q;
  logic [TW-1:0]            t_q;
  logic signed [HitW-1:0]   h_q [3];
  logic signed [CrossW-1:0] cr_q [3];
  logic                     rej_d, rej_q;

  logic                     best_valid_q;
  logic [TW-1:0]            best_dist_q;
  logic [MeshW-1:0]         best_mesh_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  logic signed [CoordW-1:0] va [3], vb [3], vc [3], vs [3];
  logic signed [EdgeW-1:0]  e1 [3], e2 [3], ed [3], ao [3];
  logic signed [WW-1:0]     w [3];

  mac_op_t                  op;
  logic signed [AccW-1:0]   acc;
  logic signed [NumW-1:0]   num_w;
  logic signed [DenW-1:0]   den_w;
  logic [NumW-1:0]          num_mag;
  logic [DenW-1:0]          den_mag;
  logic signed [HitW+FracW-1:0] hsum;
  logic                     div_start, div_done;
  logic [TW-1:0]            div_quo;
  logic                     better, nb_valid, out_free, out_load;
  logic [TW-1:0]            nb_dist;
  logic [MeshW-1:0]         nb_mesh;
  logic [1:0]               hidx;

  rtch_mac u_mac (
    .clk_i,
    .rst_ni,
    .op_i  (op),
    .acc_o (acc)
  );

  rtch_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (num_mag),
    .den_i   (den_mag),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign va[0] = item_q.a_x;
  assign va[1] = item_q.a_y;
  assign va[2] = item_q.a_z;
  assign vb[0] = item_q.b_x;
  assign vb[1] = item_q.b_y;
  assign vb[2] = item_q.b_z;
  assign vc[0] = item_q.c_x;
  assign vc[1] = item_q.c_y;
  assign vc[2] = item_q.c_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = EdgeW'(vb[k]) - EdgeW'(va[k]);
      e2[k] = EdgeW'(vc[k]) - EdgeW'(va[k]);
      ao[k] = EdgeW'(va[k]) - EdgeW'(org_q[k]);
      case (edge_q)
        2'd0: begin
          vs[k] = va[k];
          ed[k] = EdgeW'(vb[k]) - EdgeW'(va[k]);
        end
        2'd1: begin
          vs[k] = vb[k];
          ed[k] = EdgeW'(vc[k]) - EdgeW'(vb[k]);
        end
        default: begin
          vs[k] = vc[k];
          ed[k] = EdgeW'(va[k]) - EdgeW'(vc[k]);
        end
      endcase
      w[k] = WW'(h_q[k]) - WW'(vs[k]);
    end
  end

  // Split a cross component into an unsigned low part and a signed high part.
  function automatic logic signed [MulBW-1:0] lo_part(input logic signed [CrossW-1:0] c);
    lo_part = $signed(MulBW'(c[SplitSh-1:0]));
  endfunction

  function automatic logic signed [MulBW-1:0] hi_part(input logic signed [CrossW-1:0] c);
    hi_part = MulBW'($signed(c[CrossW-1:SplitSh]));
  endfunction

  // Issue at most one multiply-accumulate per step.
  always_comb begin
    op = '0;
    case (state_q)
      S_NORM: begin
        op.en = step_q <= 4'd11;
        case (step_q)
          4'd0: begin op.clr = 1'b1; op.a = MulAW'(e1[1]); op.b = MulBW'(e2[2]); end
          4'd1: begin op.neg = 1'b1; op.a = MulAW'(e1[2]); op.b = MulBW'(e2[1]); end
          4'd2: begin op.clr = 1'b1; op.a = MulAW'(e1[2]); op.b = MulBW'(e2[0]); end
          4'd3: begin op.neg = 1'b1; op.a = MulAW'(e1[0]); op.b = MulBW'(e2[2]); end
          4'd4: begin op.clr = 1'b1; op.a = MulAW'(e1[0]); op.b = MulBW'(e2[1]); end
          4'd5: begin op.neg = 1'b1; op.a = MulAW'(e1[1]); op.b = MulBW'(e2[0]); end
          4'd6: begin op.clr = 1'b1; op.a = MulAW'(n_q[0]); op.b = MulBW'(dir_q[0]); end
          4'd7: begin op.a = MulAW'(n_q[1]); op.b = MulBW'(dir_q[1]); end
          4'd8: begin op.a = MulAW'(n_q[2]); op.b = MulBW'(dir_q[2]); end
          4'd9: begin op.clr = 1'b1; op.a = MulAW'(n_q[0]); op.b = MulBW'(ao[0]); end
          4'd10: begin op.a = MulAW'(n_q[1]); op.b = MulBW'(ao[1]); end
          4'd11: begin op.a = MulAW'(n_q[2]); op.b = MulBW'(ao[2]); end
          default: ;
        endcase
      end
      S_HPT: begin
        op.en  = step_q <= 4'd2;
        op.clr = 1'b1;
        op.a   = $signed(MulAW'(t_q));
        case (step_q)
          4'd0: op.b = MulBW'(dir_q[0]);
          4'd1: op.b = MulBW'(dir_q[1]);
          default: op.b = MulBW'(dir_q[2]);
        endcase
      end
      S_EDGE: begin
        op.en = (step_q <= 4'd5) || ((step_q >= 4'd8) && (step_q <= 4'd13));
        case (step_q)
          4'd0: begin op.clr = 1'b1; op.a = MulAW'(w[2]); op.b = MulBW'(ed[1]); end
          4'd1: begin op.neg = 1'b1; op.a = MulAW'(w[1]); op.b = MulBW'(ed[2]); end
          4'd2: begin op.clr = 1'b1; op.a = MulAW'(w[0]); op.b = MulBW'(ed[2]); end
          4'd3: begin op.neg = 1'b1; op.a = MulAW'(w[2]); op.b = MulBW'(ed[0]); end
          4'd4: begin op.clr = 1'b1; op.a = MulAW'(w[1]); op.b = MulBW'(ed[0]); end
          4'd5: begin op.neg = 1'b1; op.a = MulAW'(w[0]); op.b = MulBW'(ed[1]); end
          4'd8: begin op.clr = 1'b1; op.a = MulAW'(n_q[0]); op.b = lo_part(cr_q[0]); end
          4'd9: begin op.hi = 1'b1; op.a = MulAW'(n_q[0]); op.b = hi_part(cr_q[0]); end
          4'd10: begin op.a = MulAW'(n_q[1]); op.b = lo_part(cr_q[1]); end
          4'd11: begin op.hi = 1'b1; op.a = MulAW'(n_q[1]); op.b = hi_part(cr_q[1]); end
          4'd12: begin op.a = MulAW'(n_q[2]); op.b = lo_part(cr_q[2]); end
          4'd13: begin op.hi = 1'b1; op.a = MulAW'(n_q[2]); op.b = hi_part(cr_q[2]); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign num_w   = $signed(acc[NumW-1:0]);
  assign den_w   = q_q;
  assign num_mag = num_w[NumW-1] ? NumW'(-num_w) : NumW'(num_w);
  assign den_mag = den_w[DenW-1] ? DenW'(-den_w) : DenW'(den_w);
  assign div_start = (state_q == S_NORM) && (step_q == 4'd13);

  assign hidx = 2'(step_q - 4'd2);
  always_comb begin
    case (hidx)
      2'd0: hsum = $signed(acc[HitW+FracW-1:0]) + {(HitW)'(org_q[0]), FracW'(0)};
      2'd1: hsum = $signed(acc[HitW+FracW-1:0]) + {(HitW)'(org_q[1]), FracW'(0)};
      default: hsum = $signed(acc[HitW+FracW-1:0]) + {(HitW)'(org_q[2]), FracW'(0)};
    endcase
  end

  assign better   = !rej_q && (!best_valid_q || (best_dist_q > t_q));
  assign nb_valid = better || best_valid_q;
  assign nb_dist  = better ? t_q : best_dist_q;
  assign nb_mesh  = better ? item_q.mesh_id : best_mesh_q;
  assign out_free = !(out_valid_q && out_stall_i);
  assign out_load = (state_q == S_FIN) && item_q.last_triangle && out_free;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    edge_d  = edge_q;
    rej_d   = rej_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_NORM;
          step_d  = '0;
          rej_d   = 32'(in_i.mesh_id) >= 32'(MeshCount);
        end
      end
      S_NORM: begin
        step_d = step_q + 1'b1;
        if (step_q == 4'd13) begin
          state_d = S_DIV;
          rej_d   = rej_q || (q_q == '0) ||
                    ((num_w != '0) && (num_w[NumW-1] != q_q[DenW-1]));
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_HPT;
          step_d  = '0;
        end
      end
      S_HPT: begin
        step_d = step_q + 1'b1;
        if (step_q == 4'd4) begin
          state_d = S_EDGE;
          step_d  = '0;
          edge_d  = '0;
        end
      end
      S_EDGE: begin
        step_d = step_q + 1'b1;
        if (step_q == 4'd15) begin
          rej_d = rej_q || acc[AccW-1];
          edge_d = edge_q + 1'b1;
          if (edge_q == 2'd2) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!item_q.last_triangle || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      edge_q       <= '0;
      rej_q        <= 1'b0;
      best_valid_q <= 1'b0;
      best_dist_q  <= '0;
      best_mesh_q  <= '0;
      out_valid_q  <= 1'b0;
      org_q[0]     <= '0;
      org_q[1]     <= '0;
      org_q[2]     <= '0;
      dir_q[0]     <= '0;
      dir_q[1]     <= '0;
      dir_q[2]     <= CoordW'(256);
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      edge_q  <= edge_d;
      rej_q   <= rej_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_FIN) begin
        if (!item_q.last_triangle) begin
          best_valid_q <= nb_valid;
          best_dist_q  <= nb_dist;
          best_mesh_q  <= nb_mesh;
        end else if (out_free) begin
          best_valid_q <= 1'b0;
          best_dist_q  <= '0;
          best_mesh_q  <= '0;
        end
      end
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ORG_X: org_q[0] <= cfg_data_i;
          CFG_ORG_Y: org_q[1] <= cfg_data_i;
          CFG_ORG_Z: org_q[2] <= cfg_data_i;
          CFG_DIR_X: dir_q[0] <= cfg_data_i;
          CFG_DIR_Y: dir_q[1] <= cfg_data_i;
          CFG_DIR_Z: dir_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      item_q <= in_i;
    end
    if (out_load) begin
      out_q <= '{hit: nb_valid, distance_t: nb_dist, hit_mesh: nb_mesh};
    end
    if (state_q == S_NORM) begin
      case (step_q)
        4'd3:  n_q[0] <= $signed(acc[NormW-1:0]);
        4'd5:  n_q[1] <= $signed(acc[NormW-1:0]);
        4'd7:  n_q[2] <= $signed(acc[NormW-1:0]);
        4'd10: q_q    <= $signed(acc[DenW-1:0]);
        default: ;
      endcase
    end
    if ((state_q == S_DIV) && div_done) begin
      t_q <= div_quo;
    end
    if ((state_q == S_HPT) && (step_q >= 4'd2)) begin
      case (hidx)
        2'd0: h_q[0] <= hsum[HitW+FracW-1:FracW];
        2'd1: h_q[1] <= hsum[HitW+FracW-1:FracW];
        default: h_q[2] <= hsum[HitW+FracW-1:FracW];
      endcase
    end
    if (state_q == S_EDGE) begin
      case (step_q)
        4'd3: cr_q[0] <= $signed(acc[CrossW-1:0]);
        4'd5: cr_q[1] <= $signed(acc[CrossW-1:0]);
        4'd7: cr_q[2] <= $signed(acc[CrossW-1:0]);
        default: ;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `RTCH_ASSERT(a_accept_busy, (in_valid_i && !in_stall_o) |=> (state_q == S_NORM), "accepted beat did not start work")
  `RTCH_ASSERT(a_div_in_wait, div_done |-> (state_q == S_DIV), "divider finished outside its wait state")
  `RTCH_ASSERT(a_best_clear, !best_valid_q |-> ((best_dist_q == '0) && (best_mesh_q == '0)), "empty best hit holds data")
  `RTCH_ASSERT_NEVER(a_miss_zero, out_valid_o && !out_o.hit && ((out_o.distance_t != '0) || (out_o.hit_mesh != '0)), "miss beat carries nonzero fields")

endmodule

`default_nettype wire

FILE: dv/ray_triangle_closest_hit_checker.sv
`timescale 1ns / 1ps

module ray_triangle_closest_hit_checker import rtch_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  output int                 pending_o,
  output int                 errors_o
);

  typedef logic signed [127:0] wide_t;

  longint    ray_org[3];
  longint    ray_dir[3];
  bit        best_hit;
  logic [31:0] best_t;
  logic [7:0]  best_mesh;
  out_item_t expected_q[$];

  function automatic logic [31:0] fixed_div(longint unsigned n, longint unsigned d);
    logic [127:0] quo;
    quo = (128'(n) << 16) / 128'(d);
    return (quo > 128'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
  endfunction

  function automatic bit edge_outside(longint n[3], longint e[3], longint w[3]);
    longint cx, cy, cz;
    wide_t  sum;
    cx  = e[1] * w[2] - e[2] * w[1];
    cy  = e[2] * w[0] - e[0] * w[2];
    cz  = e[0] * w[1] - e[1] * w[0];
    sum = 128'(n[0]) * 128'(cx) + 128'(n[1]) * 128'(cy) + 128'(n[2]) * 128'(cz);
    return sum < 0;
  endfunction

  function automatic bit triangle_hit(in_item_t it, output logic [31:0] t_o);
    longint va[3], vb[3], vc[3], e1[3], e2[3], n[3], h[3], e[3], w[3];
    longint den, num;
    logic [31:0] t;
    va = '{longint'(it.a_x), longint'(it.a_y), longint'(it.a_z)};
    vb = '{longint'(it.b_x), longint'(it.b_y), longint'(it.b_z)};
    vc = '{longint'(it.c_x), longint'(it.c_y), longint'(it.c_z)};
    t_o = '0;
    for (int k = 0; k < 3; k++) begin
      e1[k] = vb[k] - va[k];
      e2[k] = vc[k] - va[k];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    den = n[0] * ray_dir[0] + n[1] * ray_dir[1] + n[2] * ray_dir[2];
    if (den == 0) return 0;
    num = n[0] * (va[0] - ray_org[0]) + n[1] * (va[1] - ray_org[1])
        + n[2] * (va[2] - ray_org[2]);
    if (num != 0 && ((num < 0) != (den < 0))) return 0;
    t = fixed_div(num < 0 ? -num : num, den < 0 ? -den : den);
    for (int k = 0; k < 3; k++)
      h[k] = (ray_org[k] * 65536 + ray_dir[k] * longint'(t)) >>> 16;
    for (int k = 0; k < 3; k++) begin e[k] = vb[k] - va[k]; w[k] = h[k] - va[k]; end
    if (edge_outside(n, e, w)) return 0;
    for (int k = 0; k < 3; k++) begin e[k] = vc[k] - vb[k]; w[k] = h[k] - vb[k]; end
    if (edge_outside(n, e, w)) return 0;
    for (int k = 0; k < 3; k++) begin e[k] = va[k] - vc[k]; w[k] = h[k] - vc[k]; end
    if (edge_outside(n, e, w)) return 0;
    t_o = t;
    return 1;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] t;
    out_item_t   exp_beat;
    if (!rst_ni) begin
      ray_org   = '{0, 0, 0};
      ray_dir   = '{0, 0, 256};
      best_hit  = 0;
      best_t    = '0;
      best_mesh = '0;
      errors_o  = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ORG_X: ray_org[0] = longint'($signed(cfg_data_i));
          CFG_ORG_Y: ray_org[1] = longint'($signed(cfg_data_i));
          CFG_ORG_Z: ray_org[2] = longint'($signed(cfg_data_i));
          CFG_DIR_X: ray_dir[0] = longint'($signed(cfg_data_i));
          CFG_DIR_Y: ray_dir[1] = longint'($signed(cfg_data_i));
          CFG_DIR_Z: ray_dir[2] = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (triangle_hit(in_i, t) && (!best_hit || best_t > t)) begin
          best_hit  = 1;
          best_t    = t;
          best_mesh = in_i.mesh_id;
        end
        if (in_i.last_triangle) begin
          exp_beat.hit        = best_hit;
          exp_beat.distance_t = best_hit ? best_t : '0;
          exp_beat.hit_mesh   = best_hit ? best_mesh : '0;
          expected_q.push_back(exp_beat);
          best_hit  = 0;
          best_t    = '0;
          best_mesh = '0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat hit=%0b t=%h mesh=%0d",
                 out_i.hit, out_i.distance_t, out_i.hit_mesh);
          errors_o++;
        end else begin
          exp_beat = expected_q.pop_front();
          if (out_i.hit !== exp_beat.hit) begin
            $error("hit: expected %0b, got %0b", exp_beat.hit, out_i.hit);
            errors_o++;
          end
          if (out_i.distance_t !== exp_beat.distance_t) begin
            $error("distance_t: expected %h, got %h", exp_beat.distance_t, out_i.distance_t);
            errors_o++;
          end
          if (out_i.hit_mesh !== exp_beat.hit_mesh) begin
            $error("hit_mesh: expected %0d, got %0d", exp_beat.hit_mesh, out_i.hit_mesh);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

FILE: dv/ray_triangle_closest_hit_tb.sv
`timescale 1ns / 1ps

module ray_triangle_closest_hit_tb import rtch_pkg::*;;

  localparam int CycleLimit = 1_000_000;
  localparam int DrainCycles = 300;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  in_item_t           in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  out_item_t          out_o;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoordW-1:0]  cfg_data_i = '0;
  int                 pending;
  int                 errors;
  int                 cycles = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  logic signed [15:0] org[3];
  logic signed [15:0] dir[3];

  ray_triangle_closest_hit uut (.*);

  ray_triangle_closest_hit_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_i(out_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    @(negedge clk_i);
  endtask

  // hold off until every result is out and the block has gone quiet
  task automatic set_ray(logic [15:0] ox, oy, oz, dx, dy, dz);
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
    write_reg(CFG_ORG_X, ox);
    write_reg(CFG_ORG_Y, oy);
    write_reg(CFG_ORG_Z, oz);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    org = '{ox, oy, oz};
    dir = '{dx, dy, dz};
  endtask

  task automatic send(in_item_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_i       <= beat;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic in_item_t make_tri(logic signed [15:0] ax, ay, az, bx, by, bz,
                                        cx, cy, cz, logic [7:0] mesh, logic last);
    in_item_t beat;
    beat = '{ax, ay, az, bx, by, bz, cx, cy, cz, mesh, last};
    return beat;
  endfunction

  // triangle scattered around a point on the ray, so a good share are hits
  function automatic in_item_t near_ray_tri(logic last);
    in_item_t   beat;
    longint     k, c[3];
    logic [15:0] v[9];
    k = $urandom_range(12);
    for (int i = 0; i < 3; i++) c[i] = longint'(org[i]) + longint'(dir[i]) * k;
    for (int j = 0; j < 9; j++)
      v[j] = clamp16(c[j % 3] + longint'($urandom_range(3072)) - 1536);
    beat = '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
             8'($urandom_range(255)), last};
    return beat;
  endfunction

  function automatic in_item_t noise_tri(logic last);
    in_item_t beat;
    beat = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    beat.last_triangle = last;
    return beat;
  endfunction

  task automatic random_queries(int count);
    logic     last;
    in_item_t beat;
    for (int i = 0; i < count; i++) begin
      last = (i == count - 1) || ($urandom_range(3) == 0);
      beat = ($urandom_range(99) < 80) ? near_ray_tri(last) : noise_tri(last);
      send(beat);
    end
  endtask

  task automatic random_ray();
    set_ray(16'($signed($urandom_range(2048)) - 1024), 16'($signed($urandom_range(2048)) - 1024),
            16'($signed($urandom_range(2048)) - 1024), 16'($signed($urandom_range(512)) - 256),
            16'($signed($urandom_range(512)) - 256),
            $urandom_range(1) ? 16'($urandom_range(1024, 64)) : -16'($urandom_range(1024, 64)));
  endtask

  initial begin
    org = '{0, 0, 0};
    dir = '{0, 0, 256};
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // straight hit at t = 10 under reset ray
    send(make_tri(-256, -256, 2560, 256, -256, 2560, 0, 256, 2560, 8'd7, 1));
    // parallel, behind, degenerate, miss beside the edges
    send(make_tri(0, 0, 0, 256, 0, 0, 0, 0, 256, 8'd1, 0));
    send(make_tri(-256, -256, -2560, 256, -256, -2560, 0, 256, -2560, 8'd2, 0));
    send(make_tri(100, 100, 100, 100, 100, 100, 100, 100, 100, 8'd3, 0));
    send(make_tri(1000, 1000, 512, 2000, 1000, 512, 1500, 2000, 512, 8'd4, 1));
    // equal distance keeps earlier, closer later replaces, farther kept out
    send(make_tri(-256, -256, 1280, 256, -256, 1280, 0, 256, 1280, 8'd10, 0));
    send(make_tri(256, -256, 1280, -256, -256, 1280, 0, 256, 1280, 8'd11, 0));
    send(make_tri(-256, -256, 768, 256, -256, 768, 0, 256, 768, 8'd255, 0));
    send(make_tri(-256, -256, 2000, 256, -256, 2000, 0, 256, 2000, 8'd12, 1));
    // extreme coordinates
    send(make_tri(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
                  0, 16'sd32767, 16'sd32767, 8'd0, 1));
    send(make_tri(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
                  16'sd32767, -16'sd32768, 16'sd32767, 8'd255, 1));

    set_ray(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);
    send(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 8'd5, 0));
    send(noise_tri(1));
    set_ray(16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768);
    send(make_tri(-16'sd32768, 0, 0, 0, -16'sd32768, 0, 0, 0, -16'sd32768, 8'd6, 1));
    set_ray(0, 0, -16'sd32768, 0, 0, 1);
    send(make_tri(-256, -256, 16'sd32767, 256, -256, 16'sd32767, 0, 256, 16'sd32767, 8'd9, 1));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 32 : 0;
      for (int grp = 0; grp < 8; grp++) begin
        random_ray();
        random_queries(20);
      end
    end
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
